// ===== hw/rtl/igx_pkg.sv =====
package igx_pkg;

  localparam int PATTERN_LEN = 7;
  localparam int PAT_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  localparam logic [2:0] CMD_WRITE_ADDR = 3'd0;
  localparam logic [2:0] CMD_DATA_RX    = 3'd1;
  localparam logic [2:0] CMD_STOP       = 3'd2;
  localparam logic [2:0] CMD_READ       = 3'd3;

  localparam logic [7:0] ADDR_DIR   = 8'h00;
  localparam logic [7:0] ADDR_PORT  = 8'h09;
  localparam logic [7:0] ADDR_LATCH = 8'h0A;

  localparam logic [7:0] DIR_RESET = 8'hFF;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_ADDR = 2'd1;
  localparam logic [1:0] PHASE_DATA = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DATA  = 2'd1,
    OP_STOP  = 2'd2,
    OP_READ  = 2'd3
  } igx_op_t;

  typedef struct packed {
    igx_op_t    op;
    logic [7:0] rx_byte;
    logic [7:0] pin_value;
  } igx_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } igx_q_status_t;

  function automatic logic [7:0] sweep_byte(input logic [PAT_IDX_W-1:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0: val = 8'b1111_0000;
      3'd1: val = 8'b0111_1000;
      3'd2: val = 8'b0011_1110;
      3'd3: val = 8'b0001_1111;
      3'd4: val = 8'b0011_1110;
      3'd5: val = 8'b0111_1000;
      3'd6: val = 8'b1111_0000;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/igx_front.sv =====
module igx_front import igx_pkg::*; (
  input  logic          in_valid,
  input  logic [2:0]    cmd,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    pin_value,
  input  igx_q_status_t q_status,
  output logic          in_stall,
  output logic          push,
  output igx_entry_t    push_entry
);

  igx_op_t op;

  always_comb begin
    unique case (cmd)
      CMD_DATA_RX: op = OP_DATA;
      CMD_STOP:    op = OP_STOP;
      CMD_READ:    op = OP_READ;
      default:     op = OP_CLEAR;
    endcase
  end

  assign in_stall             = q_status.full;
  assign push                 = in_valid && !q_status.full;
  assign push_entry.op        = op;
  assign push_entry.rx_byte   = rx_byte;
  // pins are sampled when the event is taken, not when it executes
  assign push_entry.pin_value = pin_value;

endmodule

// ===== hw/rtl/igx_queue.sv =====
module igx_queue import igx_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  igx_entry_t    push_entry,
  input  logic          pop,
  output igx_q_status_t q_status,
  output igx_entry_t    head
);

  igx_entry_t mem [QUEUE_DEPTH];

  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign q_status.full     = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign q_status.nonempty = (count != '0);
  assign head              = mem[rd_ptr];

endmodule

// ===== hw/rtl/igx_back.sv =====
module igx_back import igx_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write_en,
  input  logic          cfg_write_data,
  input  igx_q_status_t q_status,
  input  igx_entry_t    head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          tx_valid,
  output logic [7:0]    tx_byte,
  output logic [7:0]    dir_bits,
  output logic [7:0]    port_bits
);

  localparam logic [PAT_IDX_W:0] PAT_END = (PAT_IDX_W+1)'(PATTERN_LEN);

  logic                 latch_mode;
  logic [1:0]           phase;
  logic [7:0]           reg_address;
  logic [7:0]           reg_data;
  logic [7:0]           dir_reg;
  logic [7:0]           port_reg;
  logic [7:0]           latch_shadow;
  logic [PAT_IDX_W-1:0] pattern_index;
  logic [7:0]           tx_hold;

  logic [1:0]           phase_next;
  logic [7:0]           reg_address_next;
  logic [7:0]           reg_data_next;
  logic [7:0]           dir_reg_next;
  logic [7:0]           port_reg_next;
  logic [7:0]           latch_shadow_next;
  logic [PAT_IDX_W-1:0] pattern_index_next;
  logic [7:0]           tx_hold_next;
  logic                 tx_valid_next;

  logic [7:0]           read_value;
  logic [PAT_IDX_W-1:0] pattern_step;
  logic [PAT_IDX_W:0]   pattern_inc;

  // the state registers double as the result payload, so update only when the slot frees
  assign pop = q_status.nonempty && (!out_valid || !out_stall);

  assign pattern_inc  = {1'b0, pattern_index} + 1'b1;
  assign pattern_step = (pattern_inc >= PAT_END) ? '0 : pattern_inc[PAT_IDX_W-1:0];

  always_comb begin
    case (reg_address)
      ADDR_DIR:   read_value = ~dir_reg;
      ADDR_PORT:  read_value = head.pin_value;
      ADDR_LATCH: read_value = latch_mode ? sweep_byte(pattern_index) : latch_shadow;
      default:    read_value = reg_data;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    reg_address_next   = reg_address;
    reg_data_next      = reg_data;
    dir_reg_next       = dir_reg;
    port_reg_next      = port_reg;
    latch_shadow_next  = latch_shadow;
    pattern_index_next = pattern_index;
    tx_hold_next       = tx_hold;
    tx_valid_next      = 1'b0;
    unique case (head.op)
      OP_CLEAR: begin
        phase_next = PHASE_IDLE;
      end
      OP_DATA: begin
        if (phase == PHASE_IDLE) begin
          reg_address_next = head.rx_byte;
          phase_next       = PHASE_ADDR;
        end else begin
          reg_data_next = head.rx_byte;
          phase_next    = PHASE_DATA;
        end
      end
      OP_STOP: begin
        // the unused fourth phase behaves like the data phase
        if (phase[1]) begin
          if (reg_address == ADDR_DIR) begin
            dir_reg_next = ~reg_data;
          end else if (reg_address == ADDR_PORT) begin
            port_reg_next     = reg_data;
            latch_shadow_next = reg_data;
          end
          phase_next = PHASE_IDLE;
        end
      end
      OP_READ: begin
        if (phase == PHASE_ADDR) begin
          reg_data_next = read_value;
          tx_hold_next  = read_value;
          tx_valid_next = 1'b1;
          phase_next    = PHASE_IDLE;
          if (reg_address == ADDR_LATCH && latch_mode) begin
            pattern_index_next = pattern_step;
          end
        end
      end
      default: begin
        phase_next = PHASE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_mode <= 1'b0;
    end else if (cfg_write_en) begin
      latch_mode <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_IDLE;
      reg_address   <= '0;
      reg_data      <= '0;
      dir_reg       <= DIR_RESET;
      port_reg      <= '0;
      latch_shadow  <= '0;
      pattern_index <= '0;
      tx_hold       <= '0;
      tx_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        reg_address   <= reg_address_next;
        reg_data      <= reg_data_next;
        dir_reg       <= dir_reg_next;
        port_reg      <= port_reg_next;
        latch_shadow  <= latch_shadow_next;
        pattern_index <= pattern_index_next;
        tx_hold       <= tx_hold_next;
        tx_valid      <= tx_valid_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tx_byte   = tx_hold;
  assign dir_bits  = dir_reg;
  assign port_bits = port_reg;

endmodule

// ===== hw/rtl/i2c_gpio_expander_slave_top.sv =====
// Register side of an I2C GPIO expander slave. Each request is one bus event (cmd,
// rx_byte, pin_value) and yields exactly one result carrying tx_valid, the transmit
// holding byte and the current direction and port bits. Requests are decoded and
// placed in a four-entry queue; the register engine takes one request per clock
// whenever the output register is free or being emptied, so the block sustains one
// request per cycle while out_stall stays low. An accepted request is written into the
// queue and then registered into the result registers. pin_value is sampled when the
// request is accepted. latch_mode may only be written while no request is in flight.
module i2c_gpio_expander_slave_top import igx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] rx_byte,
  input  logic [7:0] pin_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic [7:0] dir_bits,
  output logic [7:0] port_bits
);

  igx_q_status_t q_status;
  igx_entry_t    push_entry;
  igx_entry_t    head;
  logic          push;
  logic          pop;

  igx_front u_front (
    .in_valid   (in_valid),
    .cmd        (cmd),
    .rx_byte    (rx_byte),
    .pin_value  (pin_value),
    .q_status   (q_status),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  igx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_status   (q_status),
    .head       (head)
  );

  igx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_status       (q_status),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .tx_valid       (tx_valid),
    .tx_byte        (tx_byte),
    .dir_bits       (dir_bits),
    .port_bits      (port_bits)
  );

endmodule

// ===== test/i2c_gpio_expander_slave_checker.sv =====
module i2c_gpio_expander_slave_checker import igx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] rx_byte,
  input  logic [7:0] pin_value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       tx_valid,
  input  logic [7:0] tx_byte,
  input  logic [7:0] dir_bits,
  input  logic [7:0] port_bits,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] dir_bits;
    logic [7:0] port_bits;
  } bus_reply_t;

  // led sweep seen on latch reads in pattern mode
  localparam logic [0:7][7:0] LED_SWEEP = {
    8'hF0, 8'h78, 8'h3E, 8'h1F, 8'h3E, 8'h78, 8'hF0, 8'h00
  };

  logic [1:0]           phase;
  logic [7:0]           reg_addr;
  logic [7:0]           reg_data;
  logic [7:0]           dir_reg;
  logic [7:0]           port_reg;
  logic [7:0]           latch_shadow;
  logic [7:0]           tx_hold;
  logic [PAT_IDX_W-1:0] sweep_idx;
  logic                 latch_mode;
  bus_reply_t           reply_q[$];

  function automatic bus_reply_t bus_event_reply(input logic [2:0] c, input logic [7:0] rx,
                                                 input logic [7:0] pins);
    bus_reply_t r;
    r.tx_valid = 1'b0;
    case (c)
      CMD_WRITE_ADDR: phase = PHASE_IDLE;
      CMD_DATA_RX: begin
        if (phase == PHASE_IDLE) begin
          reg_addr = rx;
          phase    = PHASE_ADDR;
        end else begin
          reg_data = rx;
          phase    = PHASE_DATA;
        end
      end
      CMD_STOP: begin
        // unreachable phase three behaves like the data phase
        if (phase >= PHASE_DATA) begin
          if (reg_addr == ADDR_DIR) begin
            dir_reg = ~reg_data;
          end else if (reg_addr == ADDR_PORT) begin
            port_reg     = reg_data;
            latch_shadow = reg_data;
          end
          phase = PHASE_IDLE;
        end
      end
      CMD_READ: begin
        if (phase == PHASE_ADDR) begin
          if (reg_addr == ADDR_DIR) begin
            reg_data = ~dir_reg;
          end else if (reg_addr == ADDR_PORT) begin
            reg_data = pins;
          end else if (reg_addr == ADDR_LATCH) begin
            if (latch_mode) begin
              reg_data  = LED_SWEEP[sweep_idx];
              sweep_idx = (int'(sweep_idx) + 1 >= PATTERN_LEN) ? '0 : sweep_idx + 1'b1;
            end else begin
              reg_data = latch_shadow;
            end
          end
          // unknown address resends the last data byte
          tx_hold    = reg_data;
          r.tx_valid = 1'b1;
          phase      = PHASE_IDLE;
        end
      end
      default: phase = PHASE_IDLE;
    endcase
    r.tx_byte   = tx_hold;
    r.dir_bits  = dir_reg;
    r.port_bits = port_reg;
    return r;
  endfunction

  always @(posedge clk) begin
    bus_reply_t exp_r;
    if (rst) begin
      phase        = PHASE_IDLE;
      reg_addr     = '0;
      reg_data     = '0;
      dir_reg      = DIR_RESET;
      port_reg     = '0;
      latch_shadow = '0;
      tx_hold      = '0;
      sweep_idx    = '0;
      latch_mode   = 1'b0;
      fail_count   = 0;
      reply_q.delete();
    end else begin
      if (cfg_write_en) latch_mode = cfg_write_data;
      if (in_valid && !in_stall) reply_q.push_back(bus_event_reply(cmd, rx_byte, pin_value));
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_r = reply_q.pop_front();
          if (tx_valid !== exp_r.tx_valid) begin
            $error("tx_valid: expected %0h, got %0h", exp_r.tx_valid, tx_valid);
            fail_count++;
          end
          if (tx_byte !== exp_r.tx_byte) begin
            $error("tx_byte: expected %02h, got %02h", exp_r.tx_byte, tx_byte);
            fail_count++;
          end
          if (dir_bits !== exp_r.dir_bits) begin
            $error("dir_bits: expected %02h, got %02h", exp_r.dir_bits, dir_bits);
            fail_count++;
          end
          if (port_bits !== exp_r.port_bits) begin
            $error("port_bits: expected %02h, got %02h", exp_r.port_bits, port_bits);
            fail_count++;
          end
        end
      end
    end
    pending <= reply_q.size();
  end

endmodule

// ===== test/i2c_gpio_expander_slave_top_tb.sv =====
module i2c_gpio_expander_slave_top_tb;
  import igx_pkg::*;

  localparam logic [2:0] CMD_OTHER  = 3'd4;
  localparam int         LONG_HOLD  = 64;
  localparam int         IDLE_LIMIT = 2000;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       cfg_write_en   = 1'b0;
  logic       cfg_write_data = 1'b0;
  logic       in_valid       = 1'b0;
  logic [2:0] cmd            = CMD_WRITE_ADDR;
  logic [7:0] rx_byte        = 8'h00;
  logic [7:0] pin_value      = 8'h00;
  logic       out_stall      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [7:0] dir_bits;
  logic [7:0] port_bits;

  int fail_count;
  int pending;
  int hold_reqs   = 0;
  int sent        = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  i2c_gpio_expander_slave_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .pin_value     (pin_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .dir_bits      (dir_bits),
    .port_bits     (port_bits)
  );

  i2c_gpio_expander_slave_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .pin_value     (pin_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .dir_bits      (dir_bits),
    .port_bits     (port_bits),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("i2c_gpio_expander_slave_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stall patterns in segments, long hold-offs when asked
  initial begin : receiver
    int holds_done;
    int seg_len;
    int style;
    int k;
    holds_done = 0;
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        style   = $urandom_range(0, 3);
        seg_len = $urandom_range(5, 40);
        for (k = 0; k < seg_len; k++) begin
          case (style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= k[1];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic offer(input logic [2:0] c, input logic [7:0] rx, input logic [7:0] pins);
    int gap;
    in_valid  <= 1'b1;
    cmd       <= c;
    rx_byte   <= rx;
    pin_value <= pins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_latch_mode(input logic m);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic random_traffic(input int n);
    int         stop_at;
    int         nbytes;
    int         k;
    logic [7:0] a;
    stop_at = sent + n;
    while (sent < stop_at) begin
      case ($urandom_range(0, 4))
        0: a = ADDR_DIR;
        1: a = ADDR_PORT;
        2, 3: a = ADDR_LATCH;
        default: a = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 4) != 0) offer(CMD_WRITE_ADDR, 8'($urandom), 8'($urandom));
          offer(CMD_DATA_RX, a, 8'($urandom));
          nbytes = $urandom_range(0, 3);
          for (k = 0; k < nbytes; k++) offer(CMD_DATA_RX, 8'($urandom), 8'($urandom));
          offer(CMD_STOP, 8'($urandom), 8'($urandom));
        end
        4, 5, 6, 7: begin
          if ($urandom_range(0, 3) != 0) offer(CMD_WRITE_ADDR, 8'($urandom), 8'($urandom));
          offer(CMD_DATA_RX, a, 8'($urandom));
          // a stray stop here leaves the address phase in place
          if ($urandom_range(0, 7) == 0) offer(CMD_STOP, 8'($urandom), 8'($urandom));
          offer(CMD_READ, 8'($urandom), 8'($urandom));
        end
        default: offer(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [7:0] mode_plan;
    int         p;
    mode_plan = 8'b1010_1101;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // direction read back right after reset
    offer(CMD_WRITE_ADDR, 8'h00, 8'h00);
    offer(CMD_DATA_RX, ADDR_DIR, 8'hFF);
    offer(CMD_READ, 8'h00, 8'h00);
    offer(CMD_WRITE_ADDR, 8'hFF, 8'hFF);
    offer(CMD_DATA_RX, ADDR_DIR, 8'h00);
    offer(CMD_DATA_RX, 8'hA5, 8'hFF);
    offer(CMD_STOP, 8'h00, 8'h00);
    // third data byte overwrites the second
    offer(CMD_WRITE_ADDR, 8'h00, 8'h00);
    offer(CMD_DATA_RX, ADDR_PORT, 8'h00);
    offer(CMD_DATA_RX, 8'h00, 8'h00);
    offer(CMD_DATA_RX, 8'hFF, 8'h00);
    offer(CMD_STOP, 8'h00, 8'h00);
    // latch is read only
    offer(CMD_WRITE_ADDR, 8'h00, 8'h00);
    offer(CMD_DATA_RX, ADDR_LATCH, 8'h00);
    offer(CMD_DATA_RX, 8'h3C, 8'h00);
    offer(CMD_STOP, 8'h00, 8'h00);
    // stop before the data byte keeps the address phase
    offer(CMD_DATA_RX, ADDR_PORT, 8'h00);
    offer(CMD_STOP, 8'h00, 8'h00);
    offer(CMD_READ, 8'h00, 8'hFF);
    // unknown address resends the last data byte
    offer(CMD_DATA_RX, 8'hC3, 8'h00);
    offer(CMD_READ, 8'hFF, 8'h00);
    offer(CMD_READ, 8'h00, 8'h00);
    offer(CMD_DATA_RX, ADDR_DIR, 8'h00);
    offer(CMD_OTHER | 3'd3, 8'hFF, 8'hFF);
    offer(CMD_READ, 8'h00, 8'h00);
    drain();

    for (p = 0; p < 8; p++) begin
      set_latch_mode(mode_plan[p]);
      if (p == 1) begin
        // hold the result side off while requests keep coming
        hold_reqs <= hold_reqs + 1;
        burst_left = 200;
      end
      random_traffic(125);
      drain();
    end

    if (fail_count == 0) begin
      $display("i2c_gpio_expander_slave_top regression: pass");
    end else begin
      $display("i2c_gpio_expander_slave_top regression: fail");
    end
    $finish;
  end

endmodule
